// ===== sv/tssr_pkg.sv =====
// Shared types and constants for the two-sensor swipe recognizer.
`default_nettype none

package tssr_pkg;

   localparam int DISTANCE_W  = 11;
   localparam int THRESHOLD_W = 10;
   localparam int GESTURE_W   = 2;

   localparam logic [DISTANCE_W-1:0]  NO_READING      = '1;
   localparam logic [THRESHOLD_W-1:0] THRESHOLD_RESET = 10'd30;

   typedef enum logic [2:0] {
      ST_REST = 3'd0,
      ST_R1   = 3'd1,
      ST_R2   = 3'd2,
      ST_R3   = 3'd3,
      ST_L1   = 3'd4,
      ST_L2   = 3'd5,
      ST_L3   = 3'd6
   } state_type;

   typedef enum logic [1:0] {
      PAT_NONE  = 2'b00,
      PAT_RIGHT = 2'b01,
      PAT_LEFT  = 2'b10,
      PAT_BOTH  = 2'b11
   } pattern_type;

   typedef enum logic [GESTURE_W-1:0] {
      GESTURE_NONE  = 2'd0,
      GESTURE_LEFT  = 2'd1,
      GESTURE_RIGHT = 2'd2
   } gesture_type;

   typedef struct packed {
      state_type   state;
      gesture_type gesture;
   } fsm_status_type;

endpackage : tssr_pkg

`default_nettype wire

// ===== sv/tssr_fsm.sv =====
// Swipe sequence recognizer: state register, next-state and gesture logic.
`default_nettype none

module tssr_fsm
   import tssr_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           advance,
   input  pattern_type    pattern,
   output fsm_status_type status
);

   state_type   state_ff;
   state_type   state_in;
   gesture_type gesture;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_R1: begin
            if (pattern == PAT_NONE || pattern == PAT_LEFT) state_in = ST_REST;
            else if (pattern == PAT_BOTH) state_in = ST_R2;
         end
         ST_R2: begin
            if (pattern == PAT_NONE || pattern == PAT_RIGHT) state_in = ST_REST;
            else if (pattern == PAT_LEFT) state_in = ST_R3;
         end
         ST_R3: begin
            if (pattern == PAT_NONE || pattern == PAT_RIGHT) state_in = ST_REST;
         end
         ST_L1: begin
            if (pattern == PAT_NONE || pattern == PAT_RIGHT) state_in = ST_REST;
            else if (pattern == PAT_BOTH) state_in = ST_L2;
         end
         ST_L2: begin
            if (pattern == PAT_NONE || pattern == PAT_LEFT) state_in = ST_REST;
            else if (pattern == PAT_RIGHT) state_in = ST_L3;
         end
         ST_L3: begin
            if (pattern == PAT_NONE || pattern == PAT_LEFT) state_in = ST_REST;
         end
         default: begin
            // rest, and the unused encoding, which behaves like rest
            if (pattern == PAT_RIGHT) state_in = ST_R1;
            else if (pattern == PAT_LEFT) state_in = ST_L1;
            else state_in = ST_REST;
         end
      endcase
   end

   // Gesture output: report on release after the final single-sensor step
   always_comb begin
      gesture = GESTURE_NONE;
      unique case (state_ff)
         ST_R3:   if (pattern == PAT_NONE) gesture = GESTURE_LEFT;
         ST_L3:   if (pattern == PAT_NONE) gesture = GESTURE_RIGHT;
         default: gesture = GESTURE_NONE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_REST;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   assign status.state   = state_ff;
   assign status.gesture = gesture;

endmodule : tssr_fsm

`default_nettype wire

// ===== sv/two_sensor_swipe_recognizer_unit.sv =====
// Top level of the two-sensor swipe recognizer.
//
// Usage:
//   req_ channel: one transaction carries a left and a right distance
//   reading (11-bit signed, -1 means no reading). It is accepted at a
//   rising edge with req_valid high and req_stall low.
//   rsp_ channel: one transaction per accepted request carries the gesture
//   (0 none, 1 left swipe, 2 right swipe), taken when rsp_valid is high and
//   rsp_stall is low.
//   csr_ port: csr_wr_en writes csr_wr_data into the trigger threshold.
//   Write it only while no transaction is in flight.
// Path: an accepted transaction passes through an input register, then the
//   compare and sequence update feeding the result register, which drives
//   rsp_valid. Throughput: one transaction per cycle while the response is not
//   stalled, set by the single state register that is updated once per sample.
// Reset (synchronous, active high): the recognizer returns to rest, both
//   stages empty, threshold back to 30.
// Stall: a stalled response holds in the result register; the input stage
//   still fills, and req_stall rises only when both stages are occupied
//   and the response is stalled.
`default_nettype none

module two_sensor_swipe_recognizer_unit
   import tssr_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [DISTANCE_W-1:0]  req_left_distance,
   input  logic [DISTANCE_W-1:0]  req_right_distance,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [GESTURE_W-1:0]   rsp_gesture,
   input  logic                   csr_wr_en,
   input  logic [THRESHOLD_W-1:0] csr_wr_data
);

   logic [THRESHOLD_W-1:0] threshold_ff;

   // input stage
   logic                  in_valid_ff;
   logic [DISTANCE_W-1:0] left_ff;
   logic [DISTANCE_W-1:0] right_ff;

   // result stage
   logic                  out_valid_ff;
   gesture_type           gesture_ff;

   logic                  out_load;
   logic                  in_load;
   logic                  left_hit;
   logic                  right_hit;
   pattern_type           pattern;
   fsm_status_type        fsm_status;

   // Advance the result stage when the input stage holds data and the result stage is empty or being drained
   assign out_load  = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !out_load;
   assign in_load   = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= THRESHOLD_RESET;
      end else if (csr_wr_en) begin
         threshold_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (in_load || out_load) begin
         in_valid_ff <= in_load;
      end
   end

   always_ff @(posedge clock) begin
      if (in_load) begin
         left_ff  <= req_left_distance;
         right_ff <= req_right_distance;
      end
   end

   // A reading triggers when valid and, as a signed value, below threshold
   always_comb begin
      left_hit  = (left_ff != NO_READING) &&
                  ($signed(left_ff) < $signed({1'b0, threshold_ff}));
      right_hit = (right_ff != NO_READING) &&
                  ($signed(right_ff) < $signed({1'b0, threshold_ff}));
      pattern   = pattern_type'({left_hit, right_hit});
   end

   tssr_fsm u_fsm (
      .clock   (clock),
      .reset   (reset),
      .advance (out_load),
      .pattern (pattern),
      .status  (fsm_status)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_load) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         gesture_ff <= fsm_status.gesture;
      end
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_gesture = gesture_ff;

   // Assertions

   // never report the unused gesture code
   a_gesture_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_gesture != 2'd3))
      else $error("reserved gesture code on response");

   // a reported left swipe always comes from the third-step state ST_R3
   a_swipe_source: assert property (@(posedge clock) disable iff (reset)
      (out_load && fsm_status.gesture == GESTURE_LEFT) |-> (fsm_status.state == ST_R3))
      else $error("left swipe reported outside its final state");

   // after a reported swipe the recognizer is back at rest
   a_rest_after_swipe: assert property (@(posedge clock) disable iff (reset)
      (out_load && fsm_status.gesture != GESTURE_NONE) |=> (fsm_status.state == ST_REST))
      else $error("recognizer not at rest after swipe");

   // back-pressure only when both stages hold data and the response is stalled
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (in_valid_ff && out_valid_ff && rsp_stall))
      else $error("request stalled without a full pipeline");

endmodule : two_sensor_swipe_recognizer_unit

`default_nettype wire
